>>> hw/rtl/kts_pkg.sv
// shared types, keyword table and byte classes for the keyword tag scanner
package kts_pkg;

	localparam int HEAD_DEPTH       = 9;
	localparam int HEAD_W           = HEAD_DEPTH * 8;
	localparam int CNT_W            = $clog2(HEAD_DEPTH + 2);
	localparam int NUM_KEYWORDS     = 15;
	localparam int NUM_KINDS        = 10;
	localparam int KIND_W           = 4;
	localparam int OFFSET_W         = 32;
	localparam int NAME_LEN_W       = 16;
	localparam int KEYWORD_RUN_LIMIT_DEF = 128;
	localparam int LENGTH_BITS_DEF  = 16;

	localparam logic [KIND_W-1:0] KIND_METHOD    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_SUBMETHOD = 4'd7;
	localparam logic [KIND_W-1:0] KIND_NONE      = 4'd15;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BANG  = 8'd33;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_DASH  = 8'd45;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_CARET = 8'd94;
	localparam logic [7:0] CH_UNDER = 8'd95;

	typedef logic [0:HEAD_DEPTH-1][7:0] head_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [OFFSET_W-1:0]   offset;
		logic [NAME_LEN_W-1:0] length;
	} tag_t;

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} kw_hit_t;

	// keyword text, first byte in the top byte lane
	localparam logic [HEAD_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		{"class", 32'd0}, {"grammar", 16'd0}, {"method", 24'd0},
		{"module", 24'd0}, {"multi", 32'd0}, {"my", 56'd0},
		{"our", 48'd0}, {"package", 16'd0}, {"proto", 32'd0},
		{"role", 40'd0}, {"rule", 40'd0}, {"sub", 48'd0},
		{"submethod"}, {"unit", 40'd0}, {"token", 32'd0}
	};

	localparam logic [CNT_W-1:0] KW_SIZE [NUM_KEYWORDS] = '{
		4'd5, 4'd7, 4'd6, 4'd6, 4'd5, 4'd2, 4'd3, 4'd7,
		4'd5, 4'd4, 4'd4, 4'd3, 4'd9, 4'd4, 4'd5
	};

	localparam logic [KIND_W-1:0] KW_KIND [NUM_KEYWORDS] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd8, KIND_NONE, KIND_NONE, 4'd4,
		KIND_NONE, 4'd5, 4'd6, 4'd8, 4'd7, KIND_NONE, 4'd9
	};

	function automatic logic is_space(logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_delim(logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
			(b == CH_COMMA) || (b == CH_SEMI);
	endfunction

	function automatic logic is_name_char(logic [7:0] b);
		return ((b >= 8'd97) && (b <= 8'd122)) || ((b >= 8'd65) && (b <= 8'd90)) ||
			((b >= 8'd48) && (b <= 8'd57)) || (b == CH_COLON) ||
			(b == CH_DASH) || (b == CH_UNDER);
	endfunction

	function automatic kw_hit_t kw_lookup(head_t h, logic [CNT_W-1:0] cnt);
		kw_hit_t r;
		logic [HEAD_W-1:0] mask;
		r.hit  = 1'b0;
		r.kind = KIND_NONE;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			mask = ~({HEAD_W{1'b1}} >> (8 * KW_SIZE[i]));
			if ((cnt == KW_SIZE[i]) && ((h & mask) == KW_TEXT[i])) begin
				r.hit  = 1'b1;
				r.kind = KW_KIND[i];
			end
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/kts_in_reg.sv
// input register stage holding one byte beat
module kts_in_reg
	import kts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	input  logic  consume,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

>>> hw/rtl/kts_scanner.sv
// word splitting, keyword matching and name trimming state for one byte a cycle while adv is high
module kts_scanner
	import kts_pkg::*;
#(
	parameter int KEYWORD_RUN_LIMIT = KEYWORD_RUN_LIMIT_DEF,
	parameter int LENGTH_BITS       = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  item_t                item,
	input  logic [NUM_KINDS-1:0] kind_enable,
	output logic                 emit,
	output tag_t                 tag
);

	localparam int RUN_W = $clog2(KEYWORD_RUN_LIMIT + 1);
	localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(KEYWORD_RUN_LIMIT);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HEAD_DEPTH + 1);
	localparam logic [CNT_W-1:0] HEAD_LAST = CNT_W'(HEAD_DEPTH);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_CLIP = LENGTH_BITS'(17'h0FFFF);

	typedef enum logic [1:0] {
		MODE_BETWEEN,
		MODE_WORD,
		MODE_DROP
	} mode_t;

	mode_t                  mode_q, mode_d;
	head_t                  head_q, head_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [KIND_W-1:0]      lastkw_q, lastkw_d;
	logic [RUN_W-1:0]       run_q, run_d;
	logic [OFFSET_W-1:0]    offset_q, offset_d;
	logic [OFFSET_W-1:0]    start_q, start_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic                   open_q, open_d;
	logic [LENGTH_BITS-1:0] colon_q, colon_d;
	logic [7:0]             b;
	logic                   name_char;
	logic                   close;
	logic                   emit_c;
	kw_hit_t                kw;
	logic [15:0]            kind_en_ext;

	function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] x,
			logic [LENGTH_BITS-1:0] y);
		logic [LENGTH_BITS:0] s;
		s = {1'b0, x} + {1'b0, y} + (LENGTH_BITS+1)'(1);
		return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LENGTH_BITS-1:0];
	endfunction

	assign b = item.data_byte;
	assign name_char = is_name_char(b);
	assign kind_en_ext = 16'(kind_enable);

	always_comb begin
		mode_d   = mode_q;
		head_d   = head_q;
		cnt_d    = cnt_q;
		lastkw_d = lastkw_q;
		run_d    = run_q;
		offset_d = offset_q + OFFSET_W'(1);
		start_d  = start_q;
		len_d    = len_q;
		open_d   = open_q;
		colon_d  = colon_q;
		close    = 1'b0;
		emit_c   = 1'b0;

		unique case (mode_q)
			MODE_DROP: begin
				if (b == CH_LF) mode_d = MODE_BETWEEN;
			end
			MODE_WORD: begin
				if (is_delim(b)) begin
					close  = 1'b1;
					mode_d = ((b == CH_COMMA) || (b == CH_SEMI)) ? MODE_DROP : MODE_BETWEEN;
				end else begin
					if (cnt_q < HEAD_LAST) head_d[cnt_q] = b;
					if (cnt_q < CNT_MAX) cnt_d = cnt_q + CNT_W'(1);
					if (open_q) begin
						if (!name_char) begin
							open_d = 1'b0;
						end else if (b == CH_COLON) begin
							colon_d = sat_inc(colon_q, '0);
						end else begin
							len_d   = sat_inc(len_q, colon_q);
							colon_d = '0;
						end
					end
				end
			end
			default: begin
				if (is_space(b)) begin
					mode_d = MODE_BETWEEN;
				end else if ((b == CH_HASH) || (b == CH_COMMA) || (b == CH_SEMI)) begin
					mode_d = MODE_DROP;
				end else begin
					mode_d    = MODE_WORD;
					head_d[0] = b;
					cnt_d     = CNT_W'(1);
					open_d    = 1'b1;
					len_d     = '0;
					colon_d   = '0;
					if (((lastkw_q == KIND_METHOD) || (lastkw_q == KIND_SUBMETHOD)) &&
							((b == CH_BANG) || (b == CH_CARET))) begin
						start_d = offset_q + OFFSET_W'(1);
					end else begin
						start_d = offset_q;
						if (!name_char) begin
							open_d = 1'b0;
						end else if (b == CH_COLON) begin
							colon_d = LENGTH_BITS'(1);
						end else begin
							len_d = LENGTH_BITS'(1);
						end
					end
				end
			end
		endcase

		// last beat closes an open word as if a space followed
		if (item.end_of_input && (mode_d == MODE_WORD)) close = 1'b1;

		kw = kw_lookup(head_d, cnt_d);
		if (close) begin
			if (kw.hit) begin
				if (run_q < RUN_LIMIT) begin
					lastkw_d = kw.kind;
					run_d    = run_q + RUN_W'(1);
				end else begin
					run_d = '0;
				end
			end else if (run_q != '0) begin
				emit_c = (lastkw_q < KIND_W'(NUM_KINDS)) && kind_en_ext[lastkw_q] &&
					(len_d != '0);
				run_d  = '0;
			end
		end

		tag.kind   = lastkw_q;
		tag.offset = start_d;
		tag.length = (len_d > LEN_CLIP) ? 16'hFFFF : NAME_LEN_W'(len_d);

		if (item.end_of_input) begin
			mode_d   = MODE_BETWEEN;
			cnt_d    = '0;
			lastkw_d = '0;
			run_d    = '0;
			offset_d = '0;
			start_d  = '0;
			len_d    = '0;
			open_d   = 1'b0;
			colon_d  = '0;
		end
	end

	assign emit = emit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BETWEEN;
			cnt_q    <= '0;
			lastkw_q <= '0;
			run_q    <= '0;
			offset_q <= '0;
			start_q  <= '0;
			len_q    <= '0;
			open_q   <= 1'b0;
			colon_q  <= '0;
		end else if (adv) begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			lastkw_q <= lastkw_d;
			run_q    <= run_d;
			offset_q <= offset_d;
			start_q  <= start_d;
			len_q    <= len_d;
			open_q   <= open_d;
			colon_q  <= colon_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_q <= head_d;
		end
	end

endmodule

>>> hw/rtl/kts_out_reg.sv
// result register holding one tag beat
module kts_out_reg
	import kts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  tag_t  tag_in,
	output logic  out_free,
	output logic  out_valid,
	input  logic  out_ready,
	output tag_t  tag_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q <= tag_in;
		end
	end

endmodule

>>> hw/rtl/keyword_tag_scanner.sv
// top level of the keyword tag scanner
//
//   channel  signals                                   direction
//   in       in_valid in_ready data_byte end_of_input  byte beats in
//   out      out_valid out_ready tag_kind name_offset  tag beats out
//            name_length
//   cfg      cfg_valid cfg_ready kind_enable           enable register write
//
// one byte beat per cycle while the result register is free; the tag of the beat in
// the input register, if any, is loaded into the result register as that beat is taken
// the scan state updates only on adv, once per byte, which sets the one-cycle rate
// a full result register that is not taken holds the input register
// reset clears the scan state but the head bytes; kind_enable resets to all kinds enabled
module keyword_tag_scanner
	import kts_pkg::*;
#(
	parameter int KEYWORD_RUN_LIMIT = KEYWORD_RUN_LIMIT_DEF,
	parameter int LENGTH_BITS       = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_input,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     tag_kind,
	output logic [OFFSET_W-1:0]   name_offset,
	output logic [NAME_LEN_W-1:0] name_length,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [NUM_KINDS-1:0]  kind_enable
);

	logic [NUM_KINDS-1:0] kind_enable_q;
	item_t                item;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 out_free;
	logic                 adv;
	logic                 emit;
	tag_t                 tag_c;
	tag_t                 tag_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_enable_q <= {NUM_KINDS{1'b1}};
		end else if (cfg_valid && cfg_ready) begin
			kind_enable_q <= kind_enable;
		end
	end

	assign item.data_byte    = data_byte;
	assign item.end_of_input = end_of_input;
	assign adv = valid_s1 && out_free;

	kts_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.consume  (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	kts_scanner #(
		.KEYWORD_RUN_LIMIT (KEYWORD_RUN_LIMIT),
		.LENGTH_BITS       (LENGTH_BITS)
	) u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.kind_enable (kind_enable_q),
		.emit        (emit),
		.tag         (tag_c)
	);

	kts_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && emit),
		.tag_in    (tag_c),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tag_q     (tag_q)
	);

	assign tag_kind    = tag_q.kind;
	assign name_offset = tag_q.offset;
	assign name_length = tag_q.length;

endmodule
